// ===== hdl/ahc_pkg.sv =====
`timescale 1ns / 1ps

package ahc_pkg;

  // Alphabet and tree geometry
  localparam int ALPHABET_SIZE = 314;
  localparam int CODE_WIDTH    = 16;
  localparam int NODE_TOTAL    = 2 * ALPHABET_SIZE - 1;
  localparam int ROOT          = NODE_TOTAL - 1;
  localparam int LINK_TOTAL    = NODE_TOTAL + ALPHABET_SIZE;
  localparam int COUNT_DEPTH   = NODE_TOTAL + 1;
  localparam int CHILD_DEPTH   = NODE_TOTAL + 1;

  // Field and storage widths
  localparam int IDX_W   = $clog2(LINK_TOTAL);
  localparam int CNT_W   = 16;
  localparam int SYM_W   = 9;
  localparam int LEN_W   = 5;
  localparam int LIMIT_W = 16;
  localparam int BIT_W   = $clog2(CODE_WIDTH);

  // Typed constants
  localparam logic [IDX_W-1:0] IDX_NODES     = IDX_W'(NODE_TOTAL);
  localparam logic [IDX_W-1:0] IDX_ROOT      = IDX_W'(ROOT);
  localparam logic [IDX_W-1:0] IDX_ALPHA     = IDX_W'(ALPHABET_SIZE);
  localparam logic [IDX_W-1:0] IDX_LAST_LEAF = IDX_W'(ALPHABET_SIZE - 1);
  localparam logic [IDX_W-1:0] IDX_LAST_NODE = IDX_W'(ROOT - 1);
  localparam logic [IDX_W-1:0] IDX_ONE       = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_TWO       = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_ZERO      = '0;
  localparam logic [IDX_W-1:0] LEN_CODE      = IDX_W'(CODE_WIDTH);
  localparam logic [BIT_W-1:0] LOOK_TOP      = BIT_W'(CODE_WIDTH - 1);
  localparam logic [CNT_W-1:0] CNT_ONE       = CNT_W'(1);
  localparam logic [CNT_W-1:0] COUNT_END     = 16'hffff;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'h8000;

  // Datapath micro-operations
  typedef enum logic [5:0] {
    OP_INIT_LEAF, OP_INIT_NA, OP_INIT_NB, OP_INIT_NC, OP_INIT_END,
    OP_LOAD, OP_DISPATCH, OP_ENC_STEP, OP_DEC_STEP, OP_EMIT,
    OP_BMP_START, OP_BMP_RT,
    OP_RB1_HEAD, OP_RB1_CHK,
    OP_RB2_HEAD, OP_RB2_A, OP_RB2_B, OP_RB2_SCAN, OP_RB2_SCANC, OP_RB2_PUT,
    OP_RB3_HEAD, OP_RB3_A, OP_RB3_B,
    OP_BMP_LEAF, OP_BMP_C, OP_BMP_HEAD, OP_BMP_INC, OP_BMP_CMP,
    OP_BMP_SRCH, OP_BMP_SRCHC,
    OP_BMP_SW0, OP_BMP_SW1, OP_BMP_SW2, OP_BMP_SW3, OP_BMP_SW4, OP_BMP_SW5,
    OP_BMP_PAR, OP_BMP_PARC
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic skip;
    logic init_leaf_last;
    logic init_node_last;
    logic enc_more;
    logic dec_more;
    logic out_free;
    logic root_over;
    logic rb1_more;
    logic rb2_more;
    logic scan_more;
    logic scan_less;
    logic rb3_more;
    logic rb3_pair;
    logic head_ok;
    logic bigger;
    logic srch_more;
    logic par_zero;
  } status_t;

endpackage

// ===== hdl/adaptive_huffman_coder_core.sv =====
`timescale 1ns / 1ps
// Adaptive Huffman coder core, 314-symbol alphabet.
// Input channel (in_valid/in_ready): in_func 0 encodes in_symbol, 1 decodes
// from the 16-bit look-ahead window in_lookahead. Result channel
// (out_valid/out_ready): symbol, left-aligned code, code length and a
// too-long flag, one result per input transaction.
// Configuration: cfg_wr_en/cfg_wr_data write the rebuild limit.
// Reset: after reset the core builds the starting tree in its memories with
// in_ready low; configuration writes are taken throughout.
// The result comes from one read of the parent or child memory per tree
// level. The count update then climbs the tree level by level, searching
// sibling positions and swapping where the order needs it, all on the
// single count memory. A tree rebuild, when the root count reaches the
// limit, adds a sorted insertion of each new internal node.
// One transaction is in work at a time. The result sits in an output
// register, so a stalled receiver only holds the core once the next
// result is ready to be written.
module adaptive_huffman_coder_core import ahc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [LIMIT_W-1:0]    cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic [SYM_W-1:0]      in_symbol,
  input  logic [CODE_WIDTH-1:0] in_lookahead,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SYM_W-1:0]      out_symbol_out,
  output logic [CODE_WIDTH-1:0] out_code_bits,
  output logic [LEN_W-1:0]      out_code_length,
  output logic                  out_too_long
);

  cmd_t    cmd;
  status_t st;

  // Sequence the micro-operations
  ahc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // Hold the tree and perform each step
  ahc_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_func         (in_func),
    .in_symbol       (in_symbol),
    .in_lookahead    (in_lookahead),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_symbol_out  (out_symbol_out),
    .out_code_bits   (out_code_bits),
    .out_code_length (out_code_length),
    .out_too_long    (out_too_long)
  );

endmodule

// ===== hdl/ahc_ram.sv =====
`timescale 1ns / 1ps

module ahc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ahc_ctrl.sv =====
`timescale 1ns / 1ps

module ahc_ctrl import ahc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  status_t st,
  output cmd_t    cmd,
  output logic    in_ready
);

  localparam int STATE_W = 38;

  typedef enum logic [STATE_W-1:0] {
    S_INIT_LEAF = STATE_W'(1) << 0,
    S_INIT_NA   = STATE_W'(1) << 1,
    S_INIT_NB   = STATE_W'(1) << 2,
    S_INIT_NC   = STATE_W'(1) << 3,
    S_INIT_END  = STATE_W'(1) << 4,
    S_IDLE      = STATE_W'(1) << 5,
    S_DISPATCH  = STATE_W'(1) << 6,
    S_ENC_STEP  = STATE_W'(1) << 7,
    S_DEC_STEP  = STATE_W'(1) << 8,
    S_EMIT      = STATE_W'(1) << 9,
    S_BMP_START = STATE_W'(1) << 10,
    S_BMP_RT    = STATE_W'(1) << 11,
    S_RB1_HEAD  = STATE_W'(1) << 12,
    S_RB1_CHK   = STATE_W'(1) << 13,
    S_RB2_HEAD  = STATE_W'(1) << 14,
    S_RB2_A     = STATE_W'(1) << 15,
    S_RB2_B     = STATE_W'(1) << 16,
    S_RB2_SCAN  = STATE_W'(1) << 17,
    S_RB2_SCANC = STATE_W'(1) << 18,
    S_RB2_PUT   = STATE_W'(1) << 19,
    S_RB3_HEAD  = STATE_W'(1) << 20,
    S_RB3_A     = STATE_W'(1) << 21,
    S_RB3_B     = STATE_W'(1) << 22,
    S_BMP_LEAF  = STATE_W'(1) << 23,
    S_BMP_C     = STATE_W'(1) << 24,
    S_BMP_HEAD  = STATE_W'(1) << 25,
    S_BMP_INC   = STATE_W'(1) << 26,
    S_BMP_CMP   = STATE_W'(1) << 27,
    S_BMP_SRCH  = STATE_W'(1) << 28,
    S_BMP_SRCHC = STATE_W'(1) << 29,
    S_BMP_SW0   = STATE_W'(1) << 30,
    S_BMP_SW1   = STATE_W'(1) << 31,
    S_BMP_SW2   = STATE_W'(1) << 32,
    S_BMP_SW3   = STATE_W'(1) << 33,
    S_BMP_SW4   = STATE_W'(1) << 34,
    S_BMP_SW5   = STATE_W'(1) << 35,
    S_BMP_PAR   = STATE_W'(1) << 36,
    S_BMP_PARC  = STATE_W'(1) << 37
  } state_t;

  state_t state_r, state_nxt;

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT_LEAF;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Pick the next state from datapath status
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT_LEAF: if (st.init_leaf_last) state_nxt = S_INIT_NA;
      S_INIT_NA:   state_nxt = S_INIT_NB;
      S_INIT_NB:   state_nxt = S_INIT_NC;
      S_INIT_NC:   state_nxt = st.init_node_last ? S_INIT_END : S_INIT_NA;
      S_INIT_END:  state_nxt = S_IDLE;
      S_IDLE:      if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (st.func) state_nxt = S_DEC_STEP;
        else if (st.skip) state_nxt = S_EMIT;
        else state_nxt = S_ENC_STEP;
      end
      S_ENC_STEP:  if (!st.enc_more) state_nxt = S_EMIT;
      S_DEC_STEP:  if (!st.dec_more) state_nxt = S_EMIT;
      S_EMIT:      if (st.out_free) state_nxt = st.skip ? S_IDLE : S_BMP_START;
      S_BMP_START: state_nxt = S_BMP_RT;
      S_BMP_RT:    state_nxt = st.root_over ? S_RB1_HEAD : S_BMP_LEAF;
      S_RB1_HEAD:  state_nxt = st.rb1_more ? S_RB1_CHK : S_RB2_HEAD;
      S_RB1_CHK:   state_nxt = S_RB1_HEAD;
      S_RB2_HEAD:  state_nxt = st.rb2_more ? S_RB2_A : S_RB3_HEAD;
      S_RB2_A:     state_nxt = S_RB2_B;
      S_RB2_B:     state_nxt = S_RB2_SCAN;
      S_RB2_SCAN:  state_nxt = st.scan_more ? S_RB2_SCANC : S_RB2_PUT;
      S_RB2_SCANC: state_nxt = st.scan_less ? S_RB2_SCAN : S_RB2_PUT;
      S_RB2_PUT:   state_nxt = S_RB2_HEAD;
      S_RB3_HEAD:  state_nxt = st.rb3_more ? S_RB3_A : S_BMP_LEAF;
      S_RB3_A:     state_nxt = st.rb3_pair ? S_RB3_B : S_RB3_HEAD;
      S_RB3_B:     state_nxt = S_RB3_HEAD;
      S_BMP_LEAF:  state_nxt = S_BMP_C;
      S_BMP_C:     state_nxt = S_BMP_HEAD;
      S_BMP_HEAD:  state_nxt = st.head_ok ? S_BMP_INC : S_IDLE;
      S_BMP_INC:   state_nxt = S_BMP_CMP;
      S_BMP_CMP:   state_nxt = st.bigger ? S_BMP_SRCH : S_BMP_PAR;
      S_BMP_SRCH:  state_nxt = st.srch_more ? S_BMP_SRCHC : S_BMP_SW0;
      S_BMP_SRCHC: state_nxt = st.bigger ? S_BMP_SRCH : S_BMP_SW0;
      S_BMP_SW0:   state_nxt = S_BMP_SW1;
      S_BMP_SW1:   state_nxt = S_BMP_SW2;
      S_BMP_SW2:   state_nxt = S_BMP_SW3;
      S_BMP_SW3:   state_nxt = S_BMP_SW4;
      S_BMP_SW4:   state_nxt = S_BMP_SW5;
      S_BMP_SW5:   state_nxt = S_BMP_PAR;
      S_BMP_PAR:   state_nxt = S_BMP_PARC;
      S_BMP_PARC:  state_nxt = st.par_zero ? S_IDLE : S_BMP_HEAD;
      default:     state_nxt = S_INIT_LEAF;
    endcase
  end

  // Map each state to its datapath command
  always_comb begin
    cmd.op = OP_LOAD;
    case (state_r)
      S_INIT_LEAF: cmd.op = OP_INIT_LEAF;
      S_INIT_NA:   cmd.op = OP_INIT_NA;
      S_INIT_NB:   cmd.op = OP_INIT_NB;
      S_INIT_NC:   cmd.op = OP_INIT_NC;
      S_INIT_END:  cmd.op = OP_INIT_END;
      S_IDLE:      cmd.op = OP_LOAD;
      S_DISPATCH:  cmd.op = OP_DISPATCH;
      S_ENC_STEP:  cmd.op = OP_ENC_STEP;
      S_DEC_STEP:  cmd.op = OP_DEC_STEP;
      S_EMIT:      cmd.op = OP_EMIT;
      S_BMP_START: cmd.op = OP_BMP_START;
      S_BMP_RT:    cmd.op = OP_BMP_RT;
      S_RB1_HEAD:  cmd.op = OP_RB1_HEAD;
      S_RB1_CHK:   cmd.op = OP_RB1_CHK;
      S_RB2_HEAD:  cmd.op = OP_RB2_HEAD;
      S_RB2_A:     cmd.op = OP_RB2_A;
      S_RB2_B:     cmd.op = OP_RB2_B;
      S_RB2_SCAN:  cmd.op = OP_RB2_SCAN;
      S_RB2_SCANC: cmd.op = OP_RB2_SCANC;
      S_RB2_PUT:   cmd.op = OP_RB2_PUT;
      S_RB3_HEAD:  cmd.op = OP_RB3_HEAD;
      S_RB3_A:     cmd.op = OP_RB3_A;
      S_RB3_B:     cmd.op = OP_RB3_B;
      S_BMP_LEAF:  cmd.op = OP_BMP_LEAF;
      S_BMP_C:     cmd.op = OP_BMP_C;
      S_BMP_HEAD:  cmd.op = OP_BMP_HEAD;
      S_BMP_INC:   cmd.op = OP_BMP_INC;
      S_BMP_CMP:   cmd.op = OP_BMP_CMP;
      S_BMP_SRCH:  cmd.op = OP_BMP_SRCH;
      S_BMP_SRCHC: cmd.op = OP_BMP_SRCHC;
      S_BMP_SW0:   cmd.op = OP_BMP_SW0;
      S_BMP_SW1:   cmd.op = OP_BMP_SW1;
      S_BMP_SW2:   cmd.op = OP_BMP_SW2;
      S_BMP_SW3:   cmd.op = OP_BMP_SW3;
      S_BMP_SW4:   cmd.op = OP_BMP_SW4;
      S_BMP_SW5:   cmd.op = OP_BMP_SW5;
      S_BMP_PAR:   cmd.op = OP_BMP_PAR;
      S_BMP_PARC:  cmd.op = OP_BMP_PARC;
      default:     cmd.op = OP_LOAD;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== hdl/ahc_datapath.sv =====
`timescale 1ns / 1ps

module ahc_datapath import ahc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            st,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_func,
  input  logic [SYM_W-1:0]   in_symbol,
  input  logic [CODE_WIDTH-1:0] in_lookahead,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SYM_W-1:0]   out_symbol_out,
  output logic [CODE_WIDTH-1:0] out_code_bits,
  output logic [LEN_W-1:0]   out_code_length,
  output logic               out_too_long
);

  // Memory ports
  logic             cnt_we, cnt_re, chd_we, chd_re, par_we, par_re;
  logic [IDX_W-1:0] cnt_waddr, cnt_raddr, chd_waddr, chd_raddr, par_waddr, par_raddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_q;
  logic [IDX_W-1:0] chd_wdata, chd_q, par_wdata, par_q;

  // Item and walk registers
  logic                  func_r, func_nxt;
  logic [SYM_W-1:0]      sym_r, sym_nxt;
  logic [CODE_WIDTH-1:0] look_r, look_nxt;
  logic [CODE_WIDTH-1:0] code_r, code_nxt;
  logic [IDX_W-1:0]      len_r, len_nxt;
  logic [IDX_W-1:0]      i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IDX_W-1:0]      c_r, c_nxt, l_r, l_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [IDX_W-1:0]      steps_r, steps_nxt;
  logic [CNT_W-1:0]      f_r, f_nxt;
  logic [CNT_W:0]        kc_r, kc_nxt;
  logic [LIMIT_W-1:0]    limit_r, limit_nxt;

  // Result register
  logic                  out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]      out_sym_r, out_sym_nxt;
  logic [CODE_WIDTH-1:0] out_code_r, out_code_nxt;
  logic [LEN_W-1:0]      out_len_r, out_len_nxt;
  logic                  out_long_r, out_long_nxt;

  // Derived values
  logic [IDX_W-1:0]  leaf_idx, l_eff, dec_sym, dec_next;
  logic              sym_oor, dec_bit;
  logic [CNT_W:0]    half_sum;

  assign leaf_idx = IDX_W'(sym_r) + IDX_NODES;
  assign sym_oor  = (IDX_W'(sym_r) >= IDX_ALPHA);
  assign l_eff    = (l_r > IDX_ROOT) ? IDX_ROOT : l_r;
  assign dec_bit  = (len_r < LEN_CODE) ? look_r[LOOK_TOP - len_r[BIT_W-1:0]] : 1'b0;
  assign dec_next = chd_q + IDX_W'(dec_bit);
  assign half_sum = {1'b0, cnt_q} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    dec_sym = (chd_q >= IDX_NODES) ? (chd_q - IDX_NODES) : IDX_ZERO;
    if (dec_sym >= IDX_ALPHA) begin
      dec_sym = IDX_ZERO;
    end
  end

  // Status to the controller
  always_comb begin
    st.func           = func_r;
    st.skip           = !func_r && sym_oor;
    st.init_leaf_last = (i_r == IDX_LAST_LEAF);
    st.init_node_last = (j_r == IDX_ROOT);
    st.enc_more       = (len_r == IDX_ZERO) || (par_q != IDX_ROOT && len_r < IDX_NODES);
    st.dec_more       = (chd_q < IDX_NODES) && (len_r < IDX_NODES);
    st.out_free       = !out_valid_r || out_ready;
    st.root_over      = (cnt_q >= limit_r);
    st.rb1_more       = (i_r < IDX_NODES) && (j_r < IDX_ALPHA);
    st.rb2_more       = (j_r < IDX_NODES);
    st.scan_more      = (k_r != IDX_ZERO);
    st.scan_less      = (f_r < cnt_q);
    st.rb3_more       = (i_r < IDX_NODES);
    st.rb3_pair       = (chd_q < IDX_NODES);
    st.head_ok        = (steps_r < IDX_NODES) && (c_r < IDX_NODES);
    st.bigger         = (kc_r > {1'b0, cnt_q});
    st.srch_more      = (l_r < IDX_ROOT);
    st.par_zero       = (par_q == IDX_ZERO);
  end

  // Execute the current micro-operation
  always_comb begin
    cnt_we = 1'b0; cnt_waddr = '0; cnt_wdata = '0; cnt_re = 1'b0; cnt_raddr = '0;
    chd_we = 1'b0; chd_waddr = '0; chd_wdata = '0; chd_re = 1'b0; chd_raddr = '0;
    par_we = 1'b0; par_waddr = '0; par_wdata = '0; par_re = 1'b0; par_raddr = '0;
    func_nxt = func_r; sym_nxt = sym_r; look_nxt = look_r; code_nxt = code_r;
    len_nxt = len_r; i_nxt = i_r; j_nxt = j_r; k_nxt = k_r; c_nxt = c_r;
    l_nxt = l_r; a_nxt = a_r; b_nxt = b_r; steps_nxt = steps_r; f_nxt = f_r;
    kc_nxt = kc_r;
    limit_nxt = cfg_wr_en ? cfg_wr_data : limit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sym_nxt = out_sym_r; out_code_nxt = out_code_r;
    out_len_nxt = out_len_r; out_long_nxt = out_long_r;

    case (cmd.op)
      // Build the starting tree
      OP_INIT_LEAF: begin
        cnt_we = 1'b1; cnt_waddr = i_r; cnt_wdata = CNT_ONE;
        chd_we = 1'b1; chd_waddr = i_r; chd_wdata = i_r + IDX_NODES;
        par_we = 1'b1; par_waddr = i_r + IDX_NODES; par_wdata = i_r;
        if (i_r == IDX_LAST_LEAF) begin
          i_nxt = IDX_ZERO;
          j_nxt = IDX_ALPHA;
        end else begin
          i_nxt = i_r + IDX_ONE;
        end
      end
      OP_INIT_NA: begin
        cnt_re = 1'b1; cnt_raddr = i_r;
        par_we = 1'b1; par_waddr = i_r; par_wdata = j_r;
      end
      OP_INIT_NB: begin
        cnt_re = 1'b1; cnt_raddr = i_r + IDX_ONE;
        par_we = 1'b1; par_waddr = i_r + IDX_ONE; par_wdata = j_r;
        f_nxt = cnt_q;
      end
      OP_INIT_NC: begin
        cnt_we = 1'b1; cnt_waddr = j_r; cnt_wdata = f_r + cnt_q;
        chd_we = 1'b1; chd_waddr = j_r; chd_wdata = i_r;
        i_nxt = i_r + IDX_TWO;
        j_nxt = j_r + IDX_ONE;
      end
      OP_INIT_END: begin
        cnt_we = 1'b1; cnt_waddr = IDX_NODES; cnt_wdata = COUNT_END;
        chd_we = 1'b1; chd_waddr = IDX_NODES; chd_wdata = IDX_ZERO;
        par_we = 1'b1; par_waddr = IDX_ROOT; par_wdata = IDX_ZERO;
      end

      // Take a transaction and start the walk
      OP_LOAD: begin
        if (in_valid) begin
          func_nxt = in_func;
          sym_nxt  = in_symbol;
          look_nxt = in_lookahead;
          len_nxt  = IDX_ZERO;
          code_nxt = '0;
        end
      end
      OP_DISPATCH: begin
        par_re = 1'b1; par_raddr = sym_oor ? IDX_ZERO : leaf_idx;
        chd_re = 1'b1; chd_raddr = IDX_ROOT;
      end
      OP_ENC_STEP: begin
        if (st.enc_more) begin
          code_nxt = {par_q[0], code_r[CODE_WIDTH-1:1]};
          len_nxt  = len_r + IDX_ONE;
          par_re = 1'b1; par_raddr = par_q;
        end
      end
      OP_DEC_STEP: begin
        if (st.dec_more) begin
          len_nxt = len_r + IDX_ONE;
          chd_re = 1'b1; chd_raddr = dec_next;
        end else begin
          sym_nxt = SYM_W'(dec_sym);
          if (len_r >= LEN_CODE) begin
            code_nxt = look_r;
          end else begin
            code_nxt = look_r & ~({CODE_WIDTH{1'b1}} >> len_r[BIT_W-1:0]);
          end
        end
      end
      OP_EMIT: begin
        if (st.out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = sym_r;
          out_code_nxt  = code_r;
          out_long_nxt  = (len_r > LEN_CODE);
          out_len_nxt   = (len_r > LEN_CODE) ? LEN_W'(CODE_WIDTH) : LEN_W'(len_r);
        end
      end

      // Check the root against the limit
      OP_BMP_START: begin
        cnt_re = 1'b1; cnt_raddr = IDX_ROOT;
      end
      OP_BMP_RT: begin
        i_nxt = IDX_ZERO;
        j_nxt = IDX_ZERO;
      end

      // Rebuild: gather halved leaves at the bottom
      OP_RB1_HEAD: begin
        if (st.rb1_more) begin
          chd_re = 1'b1; chd_raddr = i_r;
          cnt_re = 1'b1; cnt_raddr = i_r;
        end else begin
          i_nxt = IDX_ZERO;
          j_nxt = IDX_ALPHA;
        end
      end
      OP_RB1_CHK: begin
        if (chd_q >= IDX_NODES) begin
          cnt_we = 1'b1; cnt_waddr = j_r; cnt_wdata = half_sum[CNT_W:1];
          chd_we = 1'b1; chd_waddr = j_r; chd_wdata = chd_q;
          j_nxt = j_r + IDX_ONE;
        end
        i_nxt = i_r + IDX_ONE;
      end

      // Rebuild: insert each new internal node in sorted place
      OP_RB2_HEAD: begin
        if (st.rb2_more) begin
          cnt_re = 1'b1; cnt_raddr = i_r;
        end else begin
          i_nxt = IDX_ZERO;
        end
      end
      OP_RB2_A: begin
        cnt_re = 1'b1; cnt_raddr = i_r + IDX_ONE;
        f_nxt = cnt_q;
      end
      OP_RB2_B: begin
        f_nxt = f_r + cnt_q;
        k_nxt = j_r;
      end
      OP_RB2_SCAN: begin
        if (st.scan_more) begin
          cnt_re = 1'b1; cnt_raddr = k_r - IDX_ONE;
          chd_re = 1'b1; chd_raddr = k_r - IDX_ONE;
        end
      end
      OP_RB2_SCANC: begin
        if (st.scan_less) begin
          cnt_we = 1'b1; cnt_waddr = k_r; cnt_wdata = cnt_q;
          chd_we = 1'b1; chd_waddr = k_r; chd_wdata = chd_q;
          k_nxt = k_r - IDX_ONE;
        end
      end
      OP_RB2_PUT: begin
        cnt_we = 1'b1; cnt_waddr = k_r; cnt_wdata = f_r;
        chd_we = 1'b1; chd_waddr = k_r; chd_wdata = i_r;
        i_nxt = i_r + IDX_TWO;
        j_nxt = j_r + IDX_ONE;
      end

      // Rebuild: relink parents
      OP_RB3_HEAD: begin
        if (st.rb3_more) begin
          chd_re = 1'b1; chd_raddr = i_r;
        end
      end
      OP_RB3_A: begin
        k_nxt = chd_q;
        par_we = 1'b1; par_waddr = chd_q; par_wdata = i_r;
        if (!st.rb3_pair) begin
          i_nxt = i_r + IDX_ONE;
        end
      end
      OP_RB3_B: begin
        par_we = 1'b1; par_waddr = k_r + IDX_ONE; par_wdata = i_r;
        i_nxt = i_r + IDX_ONE;
      end

      // Raise counts from the leaf up
      OP_BMP_LEAF: begin
        par_re = 1'b1; par_raddr = leaf_idx;
        steps_nxt = IDX_ZERO;
      end
      OP_BMP_C: begin
        c_nxt = par_q;
      end
      OP_BMP_HEAD: begin
        if (st.head_ok) begin
          cnt_re = 1'b1; cnt_raddr = c_r;
        end
      end
      OP_BMP_INC: begin
        kc_nxt = {1'b0, cnt_q} + {{CNT_W{1'b0}}, 1'b1};
        cnt_we = 1'b1; cnt_waddr = c_r; cnt_wdata = cnt_q + CNT_ONE;
        cnt_re = 1'b1; cnt_raddr = c_r + IDX_ONE;
      end
      OP_BMP_CMP: begin
        l_nxt = c_r + IDX_ONE;
      end
      OP_BMP_SRCH: begin
        if (st.srch_more) begin
          cnt_re = 1'b1; cnt_raddr = l_r + IDX_ONE;
        end
      end
      OP_BMP_SRCHC: begin
        if (st.bigger) begin
          l_nxt = l_r + IDX_ONE;
        end
      end

      // Swap node c with node l
      OP_BMP_SW0: begin
        l_nxt = l_eff;
        cnt_re = 1'b1; cnt_raddr = l_eff;
        chd_re = 1'b1; chd_raddr = c_r;
      end
      OP_BMP_SW1: begin
        cnt_we = 1'b1; cnt_waddr = c_r; cnt_wdata = cnt_q;
        a_nxt = chd_q;
        chd_re = 1'b1; chd_raddr = l_r;
      end
      OP_BMP_SW2: begin
        cnt_we = 1'b1; cnt_waddr = l_r; cnt_wdata = kc_r[CNT_W-1:0];
        b_nxt = chd_q;
        chd_we = 1'b1; chd_waddr = l_r; chd_wdata = a_r;
        par_we = 1'b1; par_waddr = a_r; par_wdata = l_r;
      end
      OP_BMP_SW3: begin
        if (a_r < IDX_NODES) begin
          par_we = 1'b1; par_waddr = a_r + IDX_ONE; par_wdata = l_r;
        end
      end
      OP_BMP_SW4: begin
        par_we = 1'b1; par_waddr = b_r; par_wdata = c_r;
        chd_we = 1'b1; chd_waddr = c_r; chd_wdata = b_r;
      end
      OP_BMP_SW5: begin
        if (b_r < IDX_NODES) begin
          par_we = 1'b1; par_waddr = b_r + IDX_ONE; par_wdata = c_r;
        end
        c_nxt = l_r;
      end

      // Step to the parent
      OP_BMP_PAR: begin
        par_re = 1'b1; par_raddr = c_r;
        steps_nxt = steps_r + IDX_ONE;
      end
      OP_BMP_PARC: begin
        c_nxt = par_q;
      end
      default: begin
        func_nxt = func_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      limit_r     <= LIMIT_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      limit_r     <= limit_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    sym_r      <= sym_nxt;
    look_r     <= look_nxt;
    code_r     <= code_nxt;
    len_r      <= len_nxt;
    k_r        <= k_nxt;
    c_r        <= c_nxt;
    l_r        <= l_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    steps_r    <= steps_nxt;
    f_r        <= f_nxt;
    kc_r       <= kc_nxt;
    out_sym_r  <= out_sym_nxt;
    out_code_r <= out_code_nxt;
    out_len_r  <= out_len_nxt;
    out_long_r <= out_long_nxt;
  end

  // Node counts, child links, parent links
  ahc_ram #(.WIDTH(CNT_W), .DEPTH(COUNT_DEPTH)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_q)
  );

  ahc_ram #(.WIDTH(IDX_W), .DEPTH(CHILD_DEPTH)) u_child_ram (
    .clk   (clk),
    .we    (chd_we),
    .waddr (chd_waddr),
    .wdata (chd_wdata),
    .re    (chd_re),
    .raddr (chd_raddr),
    .rdata (chd_q)
  );

  ahc_ram #(.WIDTH(IDX_W), .DEPTH(LINK_TOTAL)) u_parent_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .re    (par_re),
    .raddr (par_raddr),
    .rdata (par_q)
  );

  assign out_valid       = out_valid_r;
  assign out_symbol_out  = out_sym_r;
  assign out_code_bits   = out_code_r;
  assign out_code_length = out_len_r;
  assign out_too_long    = out_long_r;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import ahc_pkg::*;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;
  localparam int   STALL_LIMIT = 500000;
  localparam int   CFG_SETTLE  = 30000;
  localparam int   DRAIN_WAIT  = 5000;
  localparam int   HOLD_CYCLES = 3000;

  typedef struct packed {
    logic                  func;
    logic [SYM_W-1:0]      sym;
    logic [CODE_WIDTH-1:0] look;
  } coder_req_t;

  typedef struct packed {
    logic [SYM_W-1:0]      sym;
    logic [CODE_WIDTH-1:0] code;
    logic [LEN_W-1:0]      len;
    logic                  too_long;
  } coder_res_t;

  typedef struct {
    coder_req_t req;
    logic       typed;
    coder_res_t res;
  } directed_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [LIMIT_W-1:0]    cfg_wr_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_func;
  logic [SYM_W-1:0]      in_symbol;
  logic [CODE_WIDTH-1:0] in_lookahead;
  logic                  out_valid;
  logic                  out_ready;
  logic [SYM_W-1:0]      out_symbol_out;
  logic [CODE_WIDTH-1:0] out_code_bits;
  logic [LEN_W-1:0]      out_code_length;
  logic                  out_too_long;

  adaptive_huffman_coder_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_symbol(in_symbol), .in_lookahead(in_lookahead),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_symbol_out(out_symbol_out), .out_code_bits(out_code_bits),
    .out_code_length(out_code_length), .out_too_long(out_too_long)
  );

  // Shadow tree of the coder
  logic [15:0] tree_count [0:NODE_TOTAL];
  int          tree_child [0:NODE_TOTAL-1];
  int          tree_parent[0:LINK_TOTAL-1];
  int          shadow_limit;

  coder_res_t  pending_codes[$];
  int          mismatches;
  int          transactions;
  logic        row_typed;
  coder_res_t  row_result;

  function automatic void put_parent(int at, int v);
    if (at < LINK_TOTAL) tree_parent[at] = v;
  endfunction

  function automatic int parent_of(int at);
    return (at < LINK_TOTAL) ? tree_parent[at] : 0;
  endfunction

  function automatic int child_of(int at);
    return (at < NODE_TOTAL) ? tree_child[at] : 0;
  endfunction

  function automatic void plant_tree();
    int i;
    for (int n = 0; n <= NODE_TOTAL; n++) tree_count[n] = '0;
    for (int n = 0; n < NODE_TOTAL; n++) tree_child[n] = 0;
    for (int n = 0; n < LINK_TOTAL; n++) tree_parent[n] = 0;
    for (int n = 0; n < ALPHABET_SIZE; n++) begin
      tree_count[n] = 16'd1;
      tree_child[n] = n + NODE_TOTAL;
      put_parent(n + NODE_TOTAL, n);
    end
    i = 0;
    for (int j = ALPHABET_SIZE; j <= ROOT; j++) begin
      tree_count[j] = tree_count[i] + tree_count[i + 1];
      tree_child[j] = i;
      put_parent(i, j);
      put_parent(i + 1, j);
      i += 2;
    end
    tree_count[NODE_TOTAL] = COUNT_END;
    tree_parent[ROOT] = 0;
  endfunction

  // Halve the leaf counts and rebuild the sorted table
  function automatic void halve_tree();
    int j, i, k, f;
    j = 0;
    for (int n = 0; n < NODE_TOTAL && j < ALPHABET_SIZE; n++) begin
      if (tree_child[n] >= NODE_TOTAL) begin
        tree_count[j] = 16'((int'(tree_count[n]) + 1) / 2);
        tree_child[j] = tree_child[n];
        j++;
      end
    end
    i = 0;
    for (j = ALPHABET_SIZE; j < NODE_TOTAL; j++) begin
      f = (int'(tree_count[i]) + int'(tree_count[i + 1])) & 16'hffff;
      k = j;
      while (k > 0 && f < int'(tree_count[k - 1])) k--;
      for (int m = j; m > k; m--) begin
        tree_count[m] = tree_count[m - 1];
        tree_child[m] = tree_child[m - 1];
      end
      tree_count[k] = 16'(f);
      tree_child[k] = i;
      i += 2;
    end
    for (int n = 0; n < NODE_TOTAL; n++) begin
      k = tree_child[n];
      put_parent(k, n);
      if (k < NODE_TOTAL) put_parent(k + 1, n);
    end
  endfunction

  // Rebuild at the limit, raise the symbol count and restore the sibling order
  function automatic void raise_count(int sym);
    int c, k, l, a, b;
    if (int'(tree_count[ROOT]) >= shadow_limit) halve_tree();
    c = parent_of(sym + NODE_TOTAL);
    for (int steps = 0; steps < NODE_TOTAL && c < NODE_TOTAL; steps++) begin
      k = int'(tree_count[c]) + 1;
      tree_count[c] = 16'(k);
      if (k > int'(tree_count[c + 1])) begin
        l = c + 1;
        while (l < ROOT && k > int'(tree_count[l + 1])) l++;
        if (l > ROOT) l = ROOT;
        tree_count[c] = tree_count[l];
        tree_count[l] = 16'(k);
        a = tree_child[c];
        put_parent(a, l);
        if (a < NODE_TOTAL) put_parent(a + 1, l);
        b = tree_child[l];
        tree_child[l] = a;
        put_parent(b, c);
        if (b < NODE_TOTAL) put_parent(b + 1, c);
        tree_child[c] = b;
        c = l;
      end
      c = parent_of(c);
      if (c == 0) break;
    end
  endfunction

  function automatic coder_res_t code_symbol(coder_req_t req);
    coder_res_t r;
    logic [15:0] code;
    int len, k, sym, bit_in;
    code = '0;
    len  = 0;
    sym  = int'(req.sym);
    if (req.func == FUNC_ENCODE) begin
      if (sym >= ALPHABET_SIZE) begin
        r.sym = req.sym;
        r.code = '0;
        r.len = '0;
        r.too_long = 1'b0;
        return r;
      end
      k = parent_of(sym + NODE_TOTAL);
      do begin
        code = code >> 1;
        if (k % 2 == 1) code[15] = 1'b1;
        len++;
        k = parent_of(k);
      end while (k != ROOT && len < NODE_TOTAL);
    end else begin
      k = child_of(ROOT);
      while (k < NODE_TOTAL && len < NODE_TOTAL) begin
        bit_in = 0;
        if (len < CODE_WIDTH) bit_in = req.look[CODE_WIDTH - 1 - len];
        len++;
        k = child_of(k + bit_in);
      end
      sym = (k >= NODE_TOTAL) ? k - NODE_TOTAL : 0;
      if (sym >= ALPHABET_SIZE) sym = 0;
      if (len >= CODE_WIDTH) code = req.look;
      else code = req.look & (16'hffff ^ (16'hffff >> len));
    end
    raise_count(sym);
    r.sym = SYM_W'(sym);
    r.code = code;
    r.too_long = (len > CODE_WIDTH);
    r.len = LEN_W'((len > CODE_WIDTH) ? CODE_WIDTH : len);
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    coder_req_t req;
    coder_res_t want, got;
    if (!rst_n) begin
      plant_tree();
      shadow_limit = LIMIT_RESET;
    end else begin
      if (cfg_wr_en) shadow_limit = int'(cfg_wr_data);
      if (out_valid && out_ready) begin
        transactions++;
        got.sym = out_symbol_out;
        got.code = out_code_bits;
        got.len = out_code_length;
        got.too_long = out_too_long;
        if (pending_codes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result sym=%0d", got.sym);
        end else begin
          want = pending_codes.pop_front();
          if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp sym=%0d code=%h len=%0d long=%b, %s",
                       want.sym, want.code, want.len, want.too_long,
                       $sformatf("got sym=%0d code=%h len=%0d long=%b",
                                 got.sym, got.code, got.len, got.too_long));
          end
        end
      end
      if (in_valid && in_ready) begin
        transactions++;
        req.func = in_func;
        req.sym = in_symbol;
        req.look = in_lookahead;
        want = code_symbol(req);
        pending_codes.push_back(row_typed ? row_result : want);
      end
    end
  end

  // Watchdog on cycles without any transaction
  initial begin
    int idle, seen;
    idle = 0;
    seen = 0;
    forever begin
      @(posedge clk);
      if (transactions != seen) begin
        seen = transactions;
        idle = 0;
      end else if (++idle >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver stalls on its own pattern, with one long hold-off
  initial begin
    int mode, held, hold_done;
    out_ready = 1'b0;
    mode = 0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (!hold_done && transactions > 400) begin
        hold_done = 1;
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
      end else begin
        if ($urandom_range(0, 99) == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 31) != 0);
        endcase
      end
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic offer(coder_req_t req, logic typed, coder_res_t res);
    in_valid <= 1'b1;
    in_func <= req.func;
    in_symbol <= req.sym;
    in_lookahead <= req.look;
    row_typed = typed;
    row_result = res;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    while (pending_codes.size() != 0) @(negedge clk);
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic coder_req_t pick_item();
    coder_req_t req;
    int r;
    r = $urandom_range(0, 99);
    req.look = 16'($urandom);
    req.sym = 9'($urandom_range(0, ALPHABET_SIZE - 1));
    req.func = (r >= 50) ? FUNC_DECODE : FUNC_ENCODE;
    if (r < 30) req.sym = 9'($urandom_range(0, 7));
    else if (r < 35) req.sym = 9'($urandom_range(0, 511));
    else if (r >= 90) req.look = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
    return req;
  endfunction

  // Random items sent in bursts, with a gap before some bursts
  task automatic send_random(int count);
    coder_res_t none;
    int burst;
    none = '{default: '0};
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if ($urandom_range(0, 1) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 80)) @(negedge clk);
        end
      end
      burst--;
      offer(pick_item(), 1'b0, none);
    end
    in_valid <= 1'b0;
  endtask

  directed_row_t stim_rows[] = '{
    '{'{FUNC_ENCODE, 9'd0,   16'h0000}, 1'b0, '{9'd0, 16'h0000, 5'd0, 1'b0}},
    '{'{FUNC_ENCODE, 9'd313, 16'hffff}, 1'b0, '{9'd0, 16'h0000, 5'd0, 1'b0}},
    '{'{FUNC_ENCODE, 9'd314, 16'h0000}, 1'b1, '{9'd314, 16'h0000, 5'd0, 1'b0}},
    '{'{FUNC_ENCODE, 9'd511, 16'hffff}, 1'b1, '{9'd511, 16'h0000, 5'd0, 1'b0}},
    '{'{FUNC_DECODE, 9'd0,   16'h0000}, 1'b0, '{9'd0, 16'h0000, 5'd0, 1'b0}},
    '{'{FUNC_DECODE, 9'd511, 16'hffff}, 1'b0, '{9'd0, 16'h0000, 5'd0, 1'b0}},
    '{'{FUNC_DECODE, 9'd0,   16'h8000}, 1'b0, '{9'd0, 16'h0000, 5'd0, 1'b0}},
    '{'{FUNC_DECODE, 9'd0,   16'h5555}, 1'b0, '{9'd0, 16'h0000, 5'd0, 1'b0}},
    '{'{FUNC_DECODE, 9'd0,   16'haaaa}, 1'b0, '{9'd0, 16'h0000, 5'd0, 1'b0}},
    '{'{FUNC_ENCODE, 9'd1,   16'h0000}, 1'b0, '{9'd0, 16'h0000, 5'd0, 1'b0}},
    '{'{FUNC_ENCODE, 9'd0,   16'h0000}, 1'b0, '{9'd0, 16'h0000, 5'd0, 1'b0}},
    '{'{FUNC_ENCODE, 9'd0,   16'h0000}, 1'b0, '{9'd0, 16'h0000, 5'd0, 1'b0}},
    '{'{FUNC_ENCODE, 9'd256, 16'h0000}, 1'b0, '{9'd0, 16'h0000, 5'd0, 1'b0}},
    '{'{FUNC_ENCODE, 9'd313, 16'h0000}, 1'b0, '{9'd0, 16'h0000, 5'd0, 1'b0}},
    '{'{FUNC_DECODE, 9'd0,   16'hffff}, 1'b0, '{9'd0, 16'h0000, 5'd0, 1'b0}}
  };

  // Stimulus: directed rows, then random phases at several rebuild limits
  initial begin
    int drained;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_func = FUNC_ENCODE;
    in_symbol = '0;
    in_lookahead = '0;
    row_typed = 1'b0;
    row_result = '{default: '0};
    mismatches = 0;
    transactions = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[n]) offer(stim_rows[n].req, stim_rows[n].typed, stim_rows[n].res);
    row_typed = 1'b0;
    in_valid <= 1'b0;

    send_random(300);
    write_limit(16'hffff);
    send_random(250);
    write_limit(16'd2);
    send_random(15);
    write_limit(16'd300);
    send_random(200);
    write_limit(16'd1000);
    send_random(200);
    write_limit(LIMIT_RESET);
    send_random(60);

    // Drain, then let the last count update finish
    while (pending_codes.size() != 0) @(posedge clk);
    for (drained = 0; drained < DRAIN_WAIT; drained++) @(posedge clk);
    if (mismatches == 0 && pending_codes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ahc_pkg.sv
hdl/ahc_ram.sv
hdl/ahc_ctrl.sv
hdl/ahc_datapath.sv
hdl/adaptive_huffman_coder_core.sv
test/testbench.sv
